/* rtl/gif_fixed_width_code_unpacker_defines.svh */
// Assertion helpers used by the unpacker queue RTL.
`ifndef GIF_FIXED_WIDTH_CODE_UNPACKER_DEFINES_SVH
`define GIF_FIXED_WIDTH_CODE_UNPACKER_DEFINES_SVH

// Same-cycle implication.
`define GFU_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("gfu: same-cycle check failed");

// Next-cycle implication.
`define GFU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("gfu: next-cycle check failed");

`endif

/* rtl/gfu_pkg.sv */
package gfu_pkg;

  localparam logic [1:0] PH_CODE_SIZE = 2'd0;
  localparam logic [1:0] PH_BLOCK_LEN = 2'd1;
  localparam logic [1:0] PH_DATA      = 2'd2;

  localparam int unsigned NUM_CODES = 3;

  localparam logic RK_PIXEL = 1'b0;
  localparam logic RK_END   = 1'b1;

  // One queued job: a terminator, or up to three pixel indexes from one byte.
  typedef struct packed {
    logic                       term;
    logic [1:0]                 count;
    logic [NUM_CODES-1:0][7:0]  index;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

/* rtl/gif_fixed_width_code_unpacker.sv */
// Channel   Signals                                          Dir  Transfer
// data      data_valid, data_ready, data_byte[7:0]           in   valid & ready
// cfg       cfg_valid, cfg_ready, cfg_data[15:0]             in   valid & ready
// result    result_valid, result_ready, result_kind,         out  valid & ready
//           pixel_index, pixel_row, pixel_column, last_of_run
//
// Bytes are taken one per cycle while the job queue has room; the front end
// parses and cuts codes in the cycle of acceptance.
// The back end emits one result per cycle unless stalled by result_ready; a
// byte giving k pixels holds the queue head for k results, each registered.
// Reset is synchronous and clears parse state, queue and counters; image
// width resets to 1. Either side may stall independently across the queue.
module gif_fixed_width_code_unpacker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        result_kind,
  output logic [7:0]  pixel_index,
  output logic [15:0] pixel_row,
  output logic [15:0] pixel_column,
  output logic        last_of_run
);

  logic [15:0]      image_width;
  gfu_pkg::q_push_t push;
  gfu_pkg::q_head_t head;
  logic             q_full;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 16'd1;
    end else if (cfg_valid) begin
      image_width <= cfg_data;
    end
  end

  gfu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .q_full     (q_full),
    .push       (push)
  );

  gfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  gfu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .pixel_index  (pixel_index),
    .pixel_row    (pixel_row),
    .pixel_column (pixel_column),
    .last_of_run  (last_of_run)
  );

endmodule

/* rtl/gfu_front.sv */
module gfu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            data_valid,
  output logic            data_ready,
  input  logic [7:0]      data_byte,
  input  logic            q_full,
  output gfu_pkg::q_push_t push
);

  logic [1:0] phase;
  logic [3:0] code_width;
  logic [7:0] bytes_left;
  logic [7:0] pend_bits;
  logic [3:0] pend_count;

  logic        accept;
  logic [15:0] acc;
  logic [4:0]  have;
  logic [4:0]  w1, w2, w3;
  logic [9:0]  mask;
  logic [2:0][8:0] code;
  logic [2:0]  got;
  logic [2:0]  keep;
  logic [4:0]  used;
  logic [15:0] rest;
  logic [1:0]  n_keep;
  logic [2:0][7:0] packed_idx;
  logic [3:0]  clamp;
  logic [7:0]  bytes_left_next;

  assign data_ready = !q_full;
  assign accept     = data_valid && data_ready;

  assign acc  = {8'd0, pend_bits} | ({8'd0, data_byte} << pend_count);
  assign have = {1'b0, pend_count} + 5'd8;
  assign w1   = {1'b0, code_width};
  assign w2   = w1 << 1;
  assign w3   = w2 + w1;
  assign mask = (10'd1 << code_width) - 10'd1;

  assign got[0] = (have >= w1);
  assign got[1] = (have >= w2);
  assign got[2] = (have >= w3);

  assign code[0] = acc[8:0] & mask[8:0];
  assign code[1] = 9'((acc >> w1)) & mask[8:0];
  assign code[2] = 9'((acc >> w2)) & mask[8:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      keep[i] = got[i] && !code[i][code_width - 4'd1];
    end
  end

  // pack kept indexes to the low slots
  always_comb begin
    n_keep     = 2'd0;
    packed_idx = '0;
    for (int i = 0; i < 3; i++) begin
      if (keep[i]) begin
        packed_idx[n_keep] = code[i][7:0];
        n_keep             = n_keep + 2'd1;
      end
    end
  end

  always_comb begin
    if (got[2]) begin
      used = w3;
    end else if (got[1]) begin
      used = w2;
    end else if (got[0]) begin
      used = w1;
    end else begin
      used = 5'd0;
    end
  end

  assign rest            = acc >> used;
  assign bytes_left_next = bytes_left - 8'd1;

  always_comb begin
    if (data_byte < 8'd2) begin
      clamp = 4'd2;
    end else if (data_byte > 8'd8) begin
      clamp = 4'd8;
    end else begin
      clamp = data_byte[3:0];
    end
  end

  always_comb begin
    push.valid       = 1'b0;
    push.entry.term  = 1'b0;
    push.entry.count = n_keep;
    push.entry.index = packed_idx;
    if (accept) begin
      case (phase)
        gfu_pkg::PH_BLOCK_LEN: begin
          if (data_byte == 8'd0) begin
            push.valid       = 1'b1;
            push.entry.term  = 1'b1;
            push.entry.count = 2'd0;
          end
        end
        gfu_pkg::PH_DATA: begin
          push.valid = (n_keep != 2'd0);
        end
        default: begin
          push.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= gfu_pkg::PH_CODE_SIZE;
      code_width <= 4'd3;
      bytes_left <= 8'd0;
      pend_bits  <= 8'd0;
      pend_count <= 4'd0;
    end else if (accept) begin
      case (phase)
        gfu_pkg::PH_BLOCK_LEN: begin
          if (data_byte == 8'd0) begin
            phase      <= gfu_pkg::PH_CODE_SIZE;
            pend_bits  <= 8'd0;
            pend_count <= 4'd0;
          end else begin
            bytes_left <= data_byte;
            phase      <= gfu_pkg::PH_DATA;
          end
        end
        gfu_pkg::PH_DATA: begin
          pend_bits  <= rest[7:0];
          pend_count <= 4'(have - used);
          bytes_left <= bytes_left_next;
          if (bytes_left_next == 8'd0) begin
            phase <= gfu_pkg::PH_BLOCK_LEN;
          end
        end
        default: begin
          code_width <= clamp + 4'd1;
          pend_bits  <= 8'd0;
          pend_count <= 4'd0;
          bytes_left <= 8'd0;
          phase      <= gfu_pkg::PH_BLOCK_LEN;
        end
      endcase
    end
  end

endmodule

/* rtl/gfu_queue.sv */
`include "gif_fixed_width_code_unpacker_defines.svh"

module gfu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  gfu_pkg::q_push_t push,
  output logic             full,
  output gfu_pkg::q_head_t head,
  input  logic             pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  gfu_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign full       = (count == CNT_W'(DEPTH));
  assign do_push    = push.valid && !full;
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (!do_push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  `GFU_ASSERT_NOW(a_no_push_when_full, clk, rst, push.valid, !full)
  `GFU_ASSERT_NOW(a_no_pop_when_empty, clk, rst, pop, head.valid)
  `GFU_ASSERT_NEXT(a_count_grows, clk, rst, do_push && !pop, count == $past(count) + 1'b1)

endmodule

/* rtl/gfu_back.sv */
module gfu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      image_width,
  input  gfu_pkg::q_head_t head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_ready,
  output logic             result_kind,
  output logic [7:0]       pixel_index,
  output logic [15:0]      pixel_row,
  output logic [15:0]      pixel_column,
  output logic             last_of_run
);

  logic [1:0]  sub;
  logic [15:0] row;
  logic [15:0] col;

  logic        take;
  logic        wrap;
  logic [15:0] row_use;
  logic [15:0] col_use;
  logic        last_pix;

  assign take = head.valid && (!result_valid || result_ready);

  // zero width behaves as width one
  assign wrap    = (col >= image_width) && !(image_width == 16'd0 && col == 16'd0);
  assign row_use = wrap ? ((row == 16'hFFFF) ? row : row + 16'd1) : row;
  assign col_use = wrap ? 16'd0 : col;
  assign last_pix = (sub == head.entry.count - 2'd1);

  assign pop = take && (head.entry.term || last_pix);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sub          <= 2'd0;
      row          <= 16'd0;
      col          <= 16'd0;
    end else if (take) begin
      result_valid <= 1'b1;
      if (head.entry.term) begin
        row <= 16'd0;
        col <= 16'd0;
        sub <= 2'd0;
      end else begin
        row <= row_use;
        col <= col_use + 16'd1;
        sub <= last_pix ? 2'd0 : sub + 2'd1;
      end
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (head.entry.term) begin
        result_kind  <= gfu_pkg::RK_END;
        pixel_index  <= 8'd0;
        pixel_row    <= 16'd0;
        pixel_column <= 16'd0;
        last_of_run  <= 1'b1;
      end else begin
        result_kind  <= gfu_pkg::RK_PIXEL;
        pixel_index  <= head.entry.index[sub];
        pixel_row    <= row_use;
        pixel_column <= col_use;
        last_of_run  <= last_pix;
      end
    end
  end

endmodule
